/* sv/mepf_pkg.sv */
package mepf_pkg;

   // Field widths fixed by the interface
   localparam int unsigned OP_W       = 2;
   localparam int unsigned PIXEL_W    = 8;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned SIZE_W     = 7;
   localparam int unsigned OUT_ROW_W  = 6;
   localparam int unsigned OUT_COL_W  = 6;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REG_IDX_W  = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
   localparam logic [OP_W-1:0] OP_FETCH = 2'd2;

   // Search modes
   localparam logic [MODE_W-1:0] MODE_MAX   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_VALUE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_SEARCH_MODE  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SEARCH_VALUE = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_COL_COUNT    = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_MAX;
   localparam logic [PIXEL_W-1:0] VALUE_RESET = 8'd0;
   localparam logic [SIZE_W-1:0]  ROWS_RESET  = 7'd64;
   localparam logic [SIZE_W-1:0]  COLS_RESET  = 7'd64;

   localparam logic [PIXEL_W-1:0] PIXEL_MIN = 8'd0;
   localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [OUT_ROW_W-1:0] match_row;
      logic [OUT_COL_W-1:0] match_col;
      logic                 last_match;
   } rsp_type;

endpackage

/* sv/mepf_div.sv */
module mepf_div #(
   parameter int NUM_W = 13,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   // restoring divider, one quotient bit per cycle
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0] shifted;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         quo_in = NUM_W'({quo_ff, fits});
         rem_in = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

/* sv/matrix_extremum_position_finder_core.sv */
// Extremum position finder. An image of up to MAX_ROWS x MAX_COLS 8-bit pixels is loaded one
// pixel per beat in row-major order (op load) after an op begin; the running maximum and
// minimum are kept as it loads. Each op fetch returns one rsp beat: the next row-major position
// whose pixel equals the target (image max, image min, or search_value, per search_mode), with
// last_match set when no further match follows; once matches run out, found = 0 and all fields
// are zero. Begin and load produce no rsp beat. A fetch that scans occupies the block while
// the serial divider turns the resume position into row/column, then the single read port of
// the pixel store is walked one address per cycle until a second match shows up (the read
// after it is already issued) or the loaded image ends and the read and compare stages drain.
// A fetch with nothing left to find goes straight to ST_OUT. Any wait for rsp_stall to free
// the reply register adds to the fetch. req_stall is high for the whole fetch; the block
// takes one item at a time.
// Only the first rows*cols loaded pixels are searched; rows/cols of 0 act as 1 and values above
// the maximum act as the maximum. Registers (4-byte stride): search_mode, search_value,
// row_count, col_count; write them only while the block is idle.
module matrix_extremum_position_finder_core #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mepf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mepf_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mepf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mepf_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mepf_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   import mepf_pkg::*;

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = $clog2(DEPTH + 1);      // holds the cell count itself
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_OUT
   } state_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type            state_ff, state_in;

   // CSRs
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [PIXEL_W-1:0]   value_ff, value_in;
   logic [SIZE_W-1:0]    rows_ff, rows_in;
   logic [SIZE_W-1:0]    cols_ff, cols_in;

   // image bookkeeping
   logic [POS_W-1:0]     load_pos_ff, load_pos_in;
   logic [POS_W-1:0]     scan_pos_ff, scan_pos_in;
   logic [PIXEL_W-1:0]   max_ff, max_in;
   logic [PIXEL_W-1:0]   min_ff, min_in;

   // per-fetch search context
   logic [PIXEL_W-1:0]   target_ff, target_in;
   logic [POS_W-1:0]     limit_ff, limit_in;
   logic                 hit_ff, hit_in;       // first match of this fetch seen

   // read stage: address walking the store, with its row/col
   logic [POS_W-1:0]     rd_pos_ff, rd_pos_in;
   logic [ROW_W-1:0]     rd_row_ff, rd_row_in;
   logic [COL_W-1:0]     rd_col_ff, rd_col_in;

   // compare stage: position whose pixel is in rd_data_ff
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [POS_W-1:0]     cmp_pos_ff, cmp_pos_in;
   logic [ROW_W-1:0]     cmp_row_ff, cmp_row_in;
   logic [COL_W-1:0]     cmp_col_ff, cmp_col_in;

   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // pixel store
   logic [PIXEL_W-1:0]   store_mem [DEPTH];
   logic [PIXEL_W-1:0]   rd_data_ff;
   logic                 store_we;

   // ------------------------------------------------------------------
   // Derived sizes
   // ------------------------------------------------------------------
   logic [RCNT_W-1:0]    eff_rows;
   logic [CCNT_W-1:0]    eff_cols;
   logic [POS_W-1:0]     cells;
   logic [POS_W-1:0]     avail;       // searchable cells right now

   always_comb begin
      if (rows_ff == '0) begin
         eff_rows = RCNT_W'(1);
      end else if (32'(rows_ff) > 32'(MAX_ROWS)) begin
         eff_rows = RCNT_W'(MAX_ROWS);
      end else begin
         eff_rows = RCNT_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         eff_cols = CCNT_W'(1);
      end else if (32'(cols_ff) > 32'(MAX_COLS)) begin
         eff_cols = CCNT_W'(MAX_COLS);
      end else begin
         eff_cols = CCNT_W'(cols_ff);
      end
      cells = POS_W'(eff_rows) * POS_W'(eff_cols);
      avail = (load_pos_ff < cells) ? load_pos_ff : cells;
   end

   // ------------------------------------------------------------------
   // Divider: resume position -> row / column
   // ------------------------------------------------------------------
   logic              div_start;
   logic              div_done;
   logic [POS_W-1:0]  div_quot;
   logic [CCNT_W-1:0] div_rem;

   mepf_div #(
      .NUM_W (POS_W),
      .DEN_W (CCNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (scan_pos_ff),
      .den   (eff_cols),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // ------------------------------------------------------------------
   // Next-state logic
   // ------------------------------------------------------------------
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 req_take;
   logic                 rsp_take;
   logic                 rd_issue;
   logic                 cmp_hit;

   assign csr_wr   = psel && penable && pwrite;
   assign csr_idx  = paddr[CSR_ADDR_W-1:2];
   assign req_take = req_valid && (state_ff == ST_IDLE);
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rd_issue = rd_pos_ff < limit_ff;
   assign cmp_hit  = cmp_vld_ff && (rd_data_ff == target_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      value_in     = value_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      load_pos_in  = load_pos_ff;
      scan_pos_in  = scan_pos_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      target_in    = target_ff;
      limit_in     = limit_ff;
      hit_in       = hit_ff;
      rd_pos_in    = rd_pos_ff;
      rd_row_in    = rd_row_ff;
      rd_col_in    = rd_col_ff;
      cmp_vld_in   = 1'b0;
      cmp_pos_in   = cmp_pos_ff;
      cmp_row_in   = cmp_row_ff;
      cmp_col_in   = cmp_col_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      store_we     = 1'b0;
      div_start    = 1'b0;

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         unique case (csr_idx)
            REG_SEARCH_MODE:  mode_in  = pwdata[MODE_W-1:0];
            REG_SEARCH_VALUE: value_in = pwdata[PIXEL_W-1:0];
            REG_ROW_COUNT:    rows_in  = pwdata[SIZE_W-1:0];
            REG_COL_COUNT:    cols_in  = pwdata[SIZE_W-1:0];
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_data.op)
                  OP_BEGIN: begin
                     load_pos_in = '0;
                     scan_pos_in = '0;
                     max_in      = PIXEL_MIN;
                     min_in      = PIXEL_MAX;
                  end
                  OP_LOAD: begin
                     if (load_pos_ff < cells) begin
                        store_we    = 1'b1;
                        load_pos_in = load_pos_ff + POS_W'(1);
                        if (req_data.pixel > max_ff) max_in = req_data.pixel;
                        if (req_data.pixel < min_ff) min_in = req_data.pixel;
                     end
                     scan_pos_in = '0;
                  end
                  OP_FETCH: begin
                     unique case (mode_ff)
                        MODE_MAX: target_in = max_ff;
                        MODE_MIN: target_in = min_ff;
                        default:  target_in = value_ff;
                     endcase
                     limit_in = avail;
                     hit_in   = 1'b0;
                     res_in   = '0;
                     if (mode_ff == MODE_NONE || avail == '0 || scan_pos_ff >= avail) begin
                        // nothing left to find: empty reply right away
                        scan_pos_in = avail;
                        state_in    = ST_OUT;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_DIV: begin
            if (div_done) begin
               rd_pos_in = scan_pos_ff;
               rd_row_in = div_quot[ROW_W-1:0];
               rd_col_in = div_rem[COL_W-1:0];
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // read stage: one store address per cycle
            if (rd_issue) begin
               cmp_vld_in = 1'b1;
               cmp_pos_in = rd_pos_ff;
               cmp_row_in = rd_row_ff;
               cmp_col_in = rd_col_ff;
               rd_pos_in  = rd_pos_ff + POS_W'(1);
               if (CCNT_W'(rd_col_ff) + CCNT_W'(1) == eff_cols) begin
                  rd_col_in = '0;
                  rd_row_in = rd_row_ff + ROW_W'(1);
               end else begin
                  rd_col_in = rd_col_ff + COL_W'(1);
               end
            end
            // compare stage
            priority if (cmp_hit && hit_ff) begin
               // a second match exists: the reported one is not the last
               res_in.last_match = 1'b0;
               state_in          = ST_OUT;
            end else if (cmp_hit) begin
               hit_in            = 1'b1;
               res_in.found      = 1'b1;
               res_in.match_row  = OUT_ROW_W'(cmp_row_ff);
               res_in.match_col  = OUT_COL_W'(cmp_col_ff);
               res_in.last_match = 1'b1;
               scan_pos_in       = cmp_pos_ff + POS_W'(1);
            end else if (!rd_issue && !cmp_vld_ff) begin
               // pipe drained at the end of the image
               if (!hit_ff) begin
                  scan_pos_in = limit_ff;
               end
               state_in = ST_OUT;
            end else begin
               // still scanning
            end
         end

         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         value_ff     <= VALUE_RESET;
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         load_pos_ff  <= '0;
         scan_pos_ff  <= '0;
         max_ff       <= PIXEL_MIN;
         min_ff       <= PIXEL_MAX;
         hit_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         value_ff     <= value_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         load_pos_ff  <= load_pos_in;
         scan_pos_ff  <= scan_pos_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         hit_ff       <= hit_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff   <= target_in;
      limit_ff    <= limit_in;
      rd_pos_ff   <= rd_pos_in;
      rd_row_ff   <= rd_row_in;
      rd_col_ff   <= rd_col_in;
      cmp_pos_ff  <= cmp_pos_in;
      cmp_row_ff  <= cmp_row_in;
      cmp_col_ff  <= cmp_col_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pixel store: one write port (load), one registered read port (scan)
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[load_pos_ff[ADDR_W-1:0]] <= req_data.pixel;
      end
      rd_data_ff <= store_mem[rd_pos_ff[ADDR_W-1:0]];
   end

   // ------------------------------------------------------------------
   // Outputs
   // ------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pready    = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (csr_idx)
         REG_SEARCH_MODE:  prdata = CSR_DATA_W'(mode_ff);
         REG_SEARCH_VALUE: prdata = CSR_DATA_W'(value_ff);
         REG_ROW_COUNT:    prdata = CSR_DATA_W'(rows_ff);
         REG_COL_COUNT:    prdata = CSR_DATA_W'(cols_ff);
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_scan_behind_load: assert property (@(posedge clock) disable iff (reset)
      scan_pos_ff <= load_pos_ff)
      else $error("resume position ahead of load position");

   a_load_in_store: assert property (@(posedge clock) disable iff (reset)
      32'(load_pos_ff) <= DEPTH)
      else $error("load position beyond pixel store");

   a_extrema_order: assert property (@(posedge clock) disable iff (reset)
      load_pos_ff != '0 |-> min_ff <= max_ff)
      else $error("running min above running max with pixels loaded");

   a_empty_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
         rsp_data_ff.match_row == '0 && rsp_data_ff.match_col == '0 &&
         !rsp_data_ff.last_match)
      else $error("not-found reply carries nonzero fields");

   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cmp_vld_ff |-> cmp_pos_ff < limit_ff)
      else $error("compare stage outside searched range");

endmodule
